@@ sv/gdad_pkg.sv @@
package gdad_pkg;

	// Datapath widths
	localparam int TOT_W  = 16;   // ordinal sum: 31 + 366 + 32767 fits
	localparam int YEAR_W = 15;   // start year plus roll-over stays below 2^15
	localparam int PC_W   = 3;

	localparam logic [YEAR_W-1:0] YEARS_PER_CYCLE = YEAR_W'(400);
	localparam logic [YEAR_W-1:0] LAST_CYCLE_YEAR = YEAR_W'(399);
	localparam logic [YEAR_W-1:0] CENTURY_1       = YEAR_W'(100);
	localparam logic [YEAR_W-1:0] CENTURY_2       = YEAR_W'(200);
	localparam logic [YEAR_W-1:0] CENTURY_3       = YEAR_W'(300);

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations selected by the control word
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_REDUCE,
		OP_ORD,
		OP_MRESET,
		OP_WALK,
		OP_EMIT,
		OP_NOP
	} op_t;

	// Jump conditions of the control word
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_Y_BIG,
		C_ORD_MORE,
		C_WALK_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucw_t;

	typedef struct packed {
		op_t  op;
		logic load;
		logic emit;
	} dp_ctrl_t;

	typedef struct packed {
		logic y_big;
		logic ord_more;
		logic walk_more;
	} dp_stat_t;

	// Month length; months outside 1..12 have no days
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		begin
			unique case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
				MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
				default:                                   len = 5'd0;
			endcase
			return len;
		end
	endfunction

endpackage

@@ sv/gdad_useq.sv @@
module gdad_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_busy,
	input  gdad_pkg::dp_stat_t  stat,
	output gdad_pkg::dp_ctrl_t  ctrl
);

	gdad_pkg::pc_t  pc_q;
	gdad_pkg::pc_t  pc_d;
	gdad_pkg::ucw_t ucw;
	logic           jump;

	// Read the control word for the current step
	always_comb begin
		unique case (pc_q)
			3'd0:    ucw = '{gdad_pkg::OP_LOAD,   gdad_pkg::C_NO_ITEM,   3'd0};
			3'd1:    ucw = '{gdad_pkg::OP_REDUCE, gdad_pkg::C_Y_BIG,     3'd1};
			3'd2:    ucw = '{gdad_pkg::OP_ORD,    gdad_pkg::C_ORD_MORE,  3'd2};
			3'd3:    ucw = '{gdad_pkg::OP_MRESET, gdad_pkg::C_NEVER,     3'd0};
			3'd4:    ucw = '{gdad_pkg::OP_WALK,   gdad_pkg::C_WALK_MORE, 3'd4};
			3'd5:    ucw = '{gdad_pkg::OP_EMIT,   gdad_pkg::C_OUT_BUSY,  3'd5};
			3'd6:    ucw = '{gdad_pkg::OP_NOP,    gdad_pkg::C_ALWAYS,    3'd0};
			default: ucw = '{gdad_pkg::OP_NOP,    gdad_pkg::C_ALWAYS,    3'd0};
		endcase
	end

	// Evaluate the jump condition
	always_comb begin
		unique case (ucw.cond)
			gdad_pkg::C_NEVER:     jump = 1'b0;
			gdad_pkg::C_ALWAYS:    jump = 1'b1;
			gdad_pkg::C_NO_ITEM:   jump = !in_valid;
			gdad_pkg::C_Y_BIG:     jump = stat.y_big;
			gdad_pkg::C_ORD_MORE:  jump = stat.ord_more;
			gdad_pkg::C_WALK_MORE: jump = stat.walk_more;
			gdad_pkg::C_OUT_BUSY:  jump = out_busy;
			default:               jump = 1'b1;
		endcase
	end

	assign pc_d = jump ? ucw.target : pc_q + 1'b1;

	// Drive the datapath
	always_comb begin
		ctrl.op   = ucw.op;
		ctrl.load = (ucw.op == gdad_pkg::OP_LOAD) && in_valid;
		ctrl.emit = (ucw.op == gdad_pkg::OP_EMIT) && !out_busy;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

@@ sv/gdad_dpath.sv @@
module gdad_dpath (
	input  logic               clk,
	input  gdad_pkg::dp_ctrl_t ctrl,
	input  logic [4:0]         start_day,
	input  logic [3:0]         start_month,
	input  logic [13:0]        start_year,
	input  logic [14:0]        days_to_add,
	output gdad_pkg::dp_stat_t stat,
	output logic [4:0]         day_o,
	output logic [3:0]         month_o,
	output logic [13:0]        year_o
);

	logic [gdad_pkg::TOT_W-1:0]  tot_q;
	logic [3:0]                  mon_q;
	logic [3:0]                  smon_q;
	logic [gdad_pkg::YEAR_W-1:0] year_q;
	logic [gdad_pkg::YEAR_W-1:0] yrem_q;   // year modulo 400 once reduced
	logic                        leap;
	logic [4:0]                  len;
	logic [gdad_pkg::TOT_W-1:0]  len_w;

	// Leap year from the year's place in the 400-year cycle
	assign leap = (yrem_q[1:0] == 2'b00) && (yrem_q != gdad_pkg::CENTURY_1)
		&& (yrem_q != gdad_pkg::CENTURY_2) && (yrem_q != gdad_pkg::CENTURY_3);
	assign len   = gdad_pkg::month_len(mon_q, leap);
	assign len_w = gdad_pkg::TOT_W'(len);

	always_comb begin
		stat.y_big     = yrem_q >= gdad_pkg::YEARS_PER_CYCLE;
		stat.ord_more  = mon_q < smon_q;
		stat.walk_more = tot_q > len_w;
	end

	// Execute the current operation
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			gdad_pkg::OP_LOAD: begin
				if (ctrl.load) begin
					tot_q  <= gdad_pkg::TOT_W'(start_day) + gdad_pkg::TOT_W'(days_to_add);
					mon_q  <= gdad_pkg::MONTH_JAN;
					smon_q <= start_month;
					year_q <= gdad_pkg::YEAR_W'(start_year);
					yrem_q <= gdad_pkg::YEAR_W'(start_year);
				end
			end
			gdad_pkg::OP_REDUCE: begin
				if (stat.y_big) begin
					yrem_q <= yrem_q - gdad_pkg::YEARS_PER_CYCLE;
				end
			end
			gdad_pkg::OP_ORD: begin
				if (stat.ord_more) begin
					tot_q <= tot_q + len_w;
					mon_q <= mon_q + 4'd1;
				end
			end
			gdad_pkg::OP_MRESET: begin
				mon_q <= gdad_pkg::MONTH_JAN;
			end
			gdad_pkg::OP_WALK: begin
				if (stat.walk_more) begin
					tot_q <= tot_q - len_w;
					if (mon_q == gdad_pkg::MONTH_DEC) begin
						mon_q  <= gdad_pkg::MONTH_JAN;
						year_q <= year_q + 1'b1;
						yrem_q <= (yrem_q == gdad_pkg::LAST_CYCLE_YEAR) ? '0 : yrem_q + 1'b1;
					end else begin
						mon_q <= mon_q + 4'd1;
					end
				end
			end
			gdad_pkg::OP_EMIT, gdad_pkg::OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	assign day_o   = tot_q[4:0];
	assign month_o = mon_q;
	assign year_o  = year_q[13:0];

endmodule

@@ sv/gregorian_date_add_days.sv @@
// Adds a day count to a Gregorian date and returns the resulting date, with
// leap years by the 4/100/400 rule and out-of-range days rolled forward. A
// small control program steps one datapath: it takes the item, reduces the
// start year by 400 at a time to place it in the 400-year leap cycle, adds
// the months before the start month, restarts at January, walks forward one
// month per cycle with the year rolled after December, then loads the result
// register, waiting while an earlier result is held under stall, and returns.
// The input stays stalled from the item taken until the program returns, and
// the month walk mostly sets how long an item takes.
// A finished result waits in the output register while the next item is taken.
module gregorian_date_add_days (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  start_day,
	input  logic [3:0]  start_month,
	input  logic [13:0] start_year,
	input  logic [14:0] days_to_add,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  result_day,
	output logic [3:0]  result_month,
	output logic [13:0] result_year
);

	gdad_pkg::dp_ctrl_t ctrl;
	gdad_pkg::dp_stat_t stat;
	logic               out_valid_q;
	logic               out_busy;
	logic [4:0]         day_w;
	logic [3:0]         month_w;
	logic [13:0]        year_w;

	assign out_busy = out_valid_q && out_stall;
	assign in_stall = ctrl.op != gdad_pkg::OP_LOAD;

	gdad_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	gdad_dpath u_dpath (
		.clk         (clk),
		.ctrl        (ctrl),
		.start_day   (start_day),
		.start_month (start_month),
		.start_year  (start_year),
		.days_to_add (days_to_add),
		.stat        (stat),
		.day_o       (day_w),
		.month_o     (month_w),
		.year_o      (year_w)
	);

	// Hold the result item until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result_day   <= day_w;
			result_month <= month_w;
			result_year  <= year_w;
		end
	end

	assign out_valid = out_valid_q;

	// An accepted item keeps the input stalled in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after item accepted");

	// A result month always lies in January..December
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_month >= gdad_pkg::MONTH_JAN && result_month <= gdad_pkg::MONTH_DEC))
		else $error("result month out of range");

	// A result leaves only when taken
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped while stalled");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int HOLD_CYCLES  = 4000;
	localparam int DRAIN_CYCLES = 1300;
	localparam int PHASE_ITEMS  = 125;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_t;

	// Expected dates, oldest first, with the date arithmetic that fills them
	class date_scoreboard;
		date_t       expected_dates[$];
		int          fails;
		int unsigned month_table[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		function new();
			fails = 0;
		endfunction

		function bit is_leap(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		// Months outside 1..12 have no days
		function int unsigned month_days(int unsigned m, int unsigned y);
			if (m < 1 || m > 12)
				return 0;
			if (m == 2)
				return is_leap(y) ? 29 : 28;
			return month_table[m - 1];
		endfunction

		function date_t add_days(logic [4:0] d, logic [3:0] m, logic [13:0] y,
				logic [14:0] n);
			int unsigned total;
			int unsigned mon;
			int unsigned yr;
			date_t       r;
			yr    = y;
			total = d;
			// ordinal day in the start year, then the count
			for (mon = 1; mon < m; mon++)
				total += month_days(mon, yr);
			total += n;
			// walk forward from January, rolling the year after December
			mon = 1;
			while (total > month_days(mon, yr)) begin
				total -= month_days(mon, yr);
				mon++;
				if (mon > 12) begin
					mon = 1;
					yr++;
				end
			end
			r.day   = total[4:0];
			r.month = mon[3:0];
			r.year  = yr[13:0];
			return r;
		endfunction

		function void note_start(logic [4:0] d, logic [3:0] m, logic [13:0] y,
				logic [14:0] n);
			expected_dates.push_back(add_days(d, m, y, n));
		endfunction

		function void check_date(logic [4:0] d, logic [3:0] m, logic [13:0] y);
			date_t e;
			if (expected_dates.size() == 0) begin
				$error("result %0d/%0d/%0d with no item pending", d, m, y);
				fails++;
				return;
			end
			e = expected_dates.pop_front();
			if (d !== e.day) begin
				$error("result_day: expected %0d, got %0d", e.day, d);
				fails++;
			end
			if (m !== e.month) begin
				$error("result_month: expected %0d, got %0d", e.month, m);
				fails++;
			end
			if (y !== e.year) begin
				$error("result_year: expected %0d, got %0d", e.year, y);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [4:0]  start_day;
	logic [3:0]  start_month;
	logic [13:0] start_year;
	logic [14:0] days_to_add;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  result_day;
	logic [3:0]  result_month;
	logic [13:0] result_year;

	bit             no_idle  = 1'b0;
	bit             hold_req = 1'b0;
	date_scoreboard sb       = new();

	gregorian_date_add_days u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_day    (start_day),
		.start_month  (start_month),
		.start_year   (start_year),
		.days_to_add  (days_to_add),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short idles, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	// Record every accepted item
	always @(posedge clk) begin
		if (arst_n && in_valid === 1'b1 && in_stall === 1'b0)
			sb.note_start(start_day, start_month, start_year, days_to_add);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_date(result_day, result_month, result_year);
	end

	// Stall the result side at random; hold off for a long stretch on request
	initial begin
		int unsigned stall_len;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall_len = 0;
			if (hold_req) begin
				stall_len = HOLD_CYCLES;
				hold_req  = 1'b0;
			end else if (!no_idle) begin
				stall_len = pick_gap();
			end
			if (stall_len != 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Offer one item and wait until it is taken
	task automatic send_item(input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y, input logic [14:0] n);
		start_day   <= d;
		start_month <= m;
		start_year  <= y;
		days_to_add <= n;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic sender_gap();
		int unsigned gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every pending date has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_dates.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_item();
		int unsigned r;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [14:0] n;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			// valid calendar date, short or long count
			m = 4'($urandom_range(1, 12));
			y = 14'($urandom_range(1, 9999));
			d = 5'($urandom_range(1, sb.month_days(m, y)));
			n = 15'($urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, 32767));
		end else if (r < 85) begin
			// anything the fields can carry
			d = 5'($urandom);
			m = 4'($urandom);
			y = 14'($urandom);
			n = 15'($urandom);
		end else begin
			// odd days and months with small counts
			d = 5'($urandom_range(0, 31));
			m = 4'($urandom_range(0, 15));
			y = 14'($urandom_range(0, 16383));
			n = 15'($urandom_range(0, 60));
		end
		send_item(d, m, y, n);
	endtask

	initial begin
		int phase;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_day   = '0;
		start_month = '0;
		start_year  = '0;
		days_to_add = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed dates: boundaries, leap rules and odd fields
		send_item(5'd1,  4'd1,  14'd2000,  15'd1);     sender_gap();
		send_item(5'd31, 4'd12, 14'd1999,  15'd1);     sender_gap();
		send_item(5'd28, 4'd2,  14'd2000,  15'd1);     sender_gap();
		send_item(5'd28, 4'd2,  14'd1900,  15'd1);     sender_gap();
		send_item(5'd28, 4'd2,  14'd2024,  15'd1);     sender_gap();
		send_item(5'd28, 4'd2,  14'd2023,  15'd1);     sender_gap();
		send_item(5'd31, 4'd2,  14'd2021,  15'd1);     sender_gap();
		send_item(5'd31, 4'd0,  14'd2020,  15'd5);     sender_gap();
		send_item(5'd5,  4'd13, 14'd2019,  15'd3);     sender_gap();
		send_item(5'd5,  4'd14, 14'd2020,  15'd3);     sender_gap();
		send_item(5'd5,  4'd15, 14'd2021,  15'd3);     sender_gap();
		send_item(5'd0,  4'd1,  14'd2000,  15'd0);     sender_gap();
		send_item(5'd0,  4'd0,  14'd7,     15'd0);     sender_gap();
		send_item(5'd0,  4'd3,  14'd1,     15'd0);     sender_gap();
		send_item(5'd28, 4'd2,  14'd0,     15'd1);     sender_gap();
		send_item(5'd31, 4'd12, 14'd16383, 15'd32767); sender_gap();
		send_item(5'd31, 4'd15, 14'd16383, 15'd32767); sender_gap();
		send_item(5'd1,  4'd1,  14'd1,     15'd1);     sender_gap();
		send_item(5'd1,  4'd1,  14'd1,     15'd32767); sender_gap();
		send_item(5'd31, 4'd1,  14'd9999,  15'd1);     sender_gap();
		send_item(5'd31, 4'd12, 14'd9999,  15'd366);   sender_gap();
		drain();

		// Random phases: normal, back to back, long receiver hold, normal
		for (phase = 0; phase < 4; phase++) begin
			no_idle = (phase == 1);
			if (phase == 2)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				random_item();
				sender_gap();
			end
			if (phase == 0)
				drain();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.expected_dates.size() == 0)
			$display("[gregorian_date_add_days] OK");
		else
			$display("[gregorian_date_add_days] ERROR");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#40_000_000;
		$display("[gregorian_date_add_days] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/gdad_pkg.sv
sv/gdad_useq.sv
sv/gdad_dpath.sv
sv/gregorian_date_add_days.sv
test/tb_top.sv
